// ===== rtl/bmct_pkg.sv =====
// shared types, codes and helpers for the bcd mm:ss countdown timer
package bmct_pkg;

  typedef enum logic [1:0] {
    PH_SETUP = 2'd0,
    PH_PREP  = 2'd1,
    PH_MAIN  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_RAISE = 3'd2,
    OP_LOWER = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  localparam logic [1:0] DIG_SEC_UNITS = 2'd0;
  localparam logic [1:0] DIG_SEC_TENS  = 2'd1;
  localparam logic [1:0] DIG_MIN_UNITS = 2'd2;
  localparam logic [1:0] DIG_MIN_TENS  = 2'd3;

  localparam logic [3:0] UNITS_MAX    = 4'd9;
  localparam logic [3:0] SEC_TENS_MAX = 4'd5;
  localparam logic [2:0] MIN_TENS_MAX = 3'd5;

  localparam logic [6:0] PREP_RESET = 7'd10;
  localparam logic [6:0] PREP_MIN   = 7'd1;
  localparam logic [6:0] PREP_MAX   = 7'd99;

  localparam int unsigned CFG_PREP_SECONDS = 0;

  typedef struct packed {
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [3:0] sec_tens;
    logic [3:0] sec_units;
    phase_t     phase;
  } disp_t;

  typedef struct packed {
    disp_t       disp;
    logic [14:0] saved;
  } timer_t;

  // clamp the prep length to 1..99 and split it into tens and units
  function automatic logic [7:0] prep_bcd(input logic [6:0] raw);
    logic [6:0]  p;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    if (raw == 7'd0) begin
      p = PREP_MIN;
    end else if (raw > PREP_MAX) begin
      p = PREP_MAX;
    end else begin
      p = raw;
    end
    // x * 205 >> 11 equals x / 10 for x below 180
    prod = {8'b0, p} * 15'd205;
    tens = prod[14:11];
    rem  = p - ({3'b0, tens} * 7'd10);
    return {tens, rem[3:0]};
  endfunction

endpackage

// ===== rtl/bmct_cfg.sv =====
// apb configuration register holding the prep length
module bmct_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  prep_seconds
);

  logic sel_prep;

  assign sel_prep = (paddr[2] == 1'(bmct_pkg::CFG_PREP_SECONDS));
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_seconds <= bmct_pkg::PREP_RESET;
    end else if (psel && penable && pwrite && pready && sel_prep) begin
      prep_seconds <= pwdata[6:0];
    end
  end

  assign prdata = sel_prep ? {25'b0, prep_seconds} : 32'b0;

endmodule

// ===== rtl/bmct_step.sv =====
// next-state logic for one request: edits, start, ticks and clear
module bmct_step (
  input  bmct_pkg::timer_t cur,
  input  logic [2:0]       op,
  input  logic [1:0]       digit_sel,
  input  logic [6:0]       prep_seconds,
  output bmct_pkg::timer_t nxt,
  output logic             finished
);

  logic [2:0] mt;
  logic [3:0] mu;
  logic [3:0] st;
  logic [3:0] su;
  logic       at_59;
  logic [7:0] prep;

  assign prep = bmct_pkg::prep_bcd(prep_seconds);

  always_comb begin
    nxt      = cur;
    finished = 1'b0;
    mt       = cur.disp.min_tens;
    mu       = cur.disp.min_units;
    st       = cur.disp.sec_tens;
    su       = cur.disp.sec_units;
    at_59    = (mt == bmct_pkg::MIN_TENS_MAX) && (mu == bmct_pkg::UNITS_MAX);

    case (bmct_pkg::op_t'(op))
      bmct_pkg::OP_TICK: begin
        if (cur.disp.phase == bmct_pkg::PH_PREP || cur.disp.phase == bmct_pkg::PH_MAIN) begin
          if (su == 4'd0 && st == 4'd0 && mu == 4'd0 && mt == 3'd0) begin
            if (cur.disp.phase == bmct_pkg::PH_MAIN) begin
              nxt.disp.phase = bmct_pkg::PH_DONE;
              finished       = 1'b1;
            end
          end else if (su != 4'd0) begin
            su = su - 4'd1;
          end else if (st != 4'd0) begin
            st = st - 4'd1;
            su = bmct_pkg::UNITS_MAX;
          end else if (mu != 4'd0) begin
            mu = mu - 4'd1;
            st = bmct_pkg::SEC_TENS_MAX;
            su = bmct_pkg::UNITS_MAX;
          end else begin
            mt = mt - 3'd1;
            mu = bmct_pkg::UNITS_MAX;
            st = bmct_pkg::SEC_TENS_MAX;
            su = bmct_pkg::UNITS_MAX;
          end
          // prep end loads the saved setting
          if (cur.disp.phase == bmct_pkg::PH_PREP && st == 4'd0 && su == 4'd0) begin
            mt             = cur.saved[14:12];
            mu             = cur.saved[11:8];
            st             = cur.saved[7:4];
            su             = cur.saved[3:0];
            nxt.disp.phase = bmct_pkg::PH_MAIN;
          end
        end
      end
      bmct_pkg::OP_START: begin
        if (cur.disp.phase == bmct_pkg::PH_SETUP) begin
          nxt.saved      = {mt, mu, st, su};
          mt             = 3'd0;
          mu             = 4'd0;
          st             = prep[7:4];
          su             = prep[3:0];
          nxt.disp.phase = bmct_pkg::PH_PREP;
        end
      end
      bmct_pkg::OP_RAISE: begin
        if (cur.disp.phase == bmct_pkg::PH_SETUP) begin
          case (digit_sel)
            bmct_pkg::DIG_SEC_UNITS: begin
              if (su < bmct_pkg::UNITS_MAX) begin
                su = su + 4'd1;
              end else if (st < bmct_pkg::SEC_TENS_MAX) begin
                su = 4'd0;
                st = st + 4'd1;
              end else if (!at_59) begin
                su = 4'd0;
                st = 4'd0;
                if (mu < bmct_pkg::UNITS_MAX) begin
                  mu = mu + 4'd1;
                end else if (mt < bmct_pkg::MIN_TENS_MAX) begin
                  mu = 4'd0;
                  mt = mt + 3'd1;
                end
              end
            end
            bmct_pkg::DIG_SEC_TENS: begin
              if (st < bmct_pkg::SEC_TENS_MAX) begin
                st = st + 4'd1;
              end else if (!at_59) begin
                st = 4'd0;
                if (mu < bmct_pkg::UNITS_MAX) begin
                  mu = mu + 4'd1;
                end else if (mt < bmct_pkg::MIN_TENS_MAX) begin
                  mu = 4'd0;
                  mt = mt + 3'd1;
                end
              end
            end
            bmct_pkg::DIG_MIN_UNITS: begin
              if (mu < bmct_pkg::UNITS_MAX) begin
                mu = mu + 4'd1;
              end else if (mt < bmct_pkg::MIN_TENS_MAX) begin
                mu = 4'd0;
                mt = mt + 3'd1;
              end
            end
            default: begin
              if (mt < bmct_pkg::MIN_TENS_MAX) begin
                mt = mt + 3'd1;
              end
            end
          endcase
        end
      end
      bmct_pkg::OP_LOWER: begin
        if (cur.disp.phase == bmct_pkg::PH_SETUP) begin
          case (digit_sel)
            bmct_pkg::DIG_SEC_UNITS: if (su != 4'd0) su = su - 4'd1;
            bmct_pkg::DIG_SEC_TENS:  if (st != 4'd0) st = st - 4'd1;
            bmct_pkg::DIG_MIN_UNITS: if (mu != 4'd0) mu = mu - 4'd1;
            default:                 if (mt != 3'd0) mt = mt - 3'd1;
          endcase
        end
      end
      bmct_pkg::OP_CLEAR: begin
        mt             = 3'd0;
        mu             = 4'd0;
        st             = 4'd0;
        su             = 4'd0;
        nxt.disp.phase = bmct_pkg::PH_SETUP;
      end
      default: begin
      end
    endcase

    nxt.disp.min_tens  = mt;
    nxt.disp.min_units = mu;
    nxt.disp.sec_tens  = st;
    nxt.disp.sec_units = su;
  end

endmodule

// ===== rtl/bcd_mmss_countdown_timer_unit.sv =====
// top level of the bcd mm:ss countdown timer with stream ports and apb setup
// Each request (a one-second tick, start, raise or lower of one digit, or clear)
// gives one result with the four shown digits, the phase and a finished flag.
// A request is captured in an input register, updates the timer state through
// one pass of digit logic and lands in a result register, so one request per
// cycle is taken while the result is not stalled; the input and result
// registers are the only buffers, so a stalled result stalls the input
// only once both registers are full. The prep length register sits at byte
// address 0 and resets to 10 seconds.
module bcd_mmss_countdown_timer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] digit_sel
  input  logic [2:0]  s_tuser,   // [2:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] min_tens, [6:3] min_units, [10:7] sec_tens,
                                 // [14:11] sec_units
  output logic [1:0]  m_tuser,   // [1:0] phase
  output logic        m_tlast,   // finished
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_valid;
  logic [2:0]       in_op;
  logic [1:0]       in_sel;
  logic             advance;
  logic [6:0]       prep_seconds;
  bmct_pkg::timer_t timer;
  bmct_pkg::timer_t timer_next;
  logic             finished_next;
  logic             out_valid;
  bmct_pkg::disp_t  out_disp;
  logic             out_finished;

  bmct_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .prep_seconds (prep_seconds)
  );

  bmct_step u_step (
    .cur          (timer),
    .op           (in_op),
    .digit_sel    (in_sel),
    .prep_seconds (prep_seconds),
    .nxt          (timer_next),
    .finished     (finished_next)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= s_tuser;
      in_sel <= s_tdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (advance) begin
      timer <= timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_disp     <= timer_next.disp;
      out_finished <= finished_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_disp.sec_units, out_disp.sec_tens,
                     out_disp.min_units, out_disp.min_tens};
  assign m_tuser  = out_disp.phase;
  assign m_tlast  = out_finished;

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == bmct_pkg::PH_DONE)
    else $error("finished flag outside done phase");

  a_prep_min_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bmct_pkg::PH_PREP |-> m_tdata[6:0] == 7'd0)
    else $error("minutes shown during preparation");

  a_digits_bcd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'd5 && m_tdata[6:3] <= 4'd9 &&
                 m_tdata[10:7] <= 4'd9 && m_tdata[14:11] <= 4'd9)
    else $error("digit out of range");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed request gave no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while empty");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the bcd mm:ss countdown timer unit
module tb;

  typedef struct {
    logic [2:0] op;
    logic [1:0] sel;
  } press_t;

  typedef struct packed {
    logic [2:0]       min_tens;
    logic [3:0]       min_units;
    logic [3:0]       sec_tens;
    logic [3:0]       sec_units;
    bmct_pkg::phase_t phase;
    logic             finished;
  } disp_exp_t;

  localparam logic [2:0] PREP_ADDR = 3'(4 * bmct_pkg::CFG_PREP_SECONDS);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [1:0] digit_sel
  logic [2:0]  s_tuser = 3'd0;   // [2:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // [2:0] min_tens, [6:3] min_units, [10:7] sec_tens,
                                 // [14:11] sec_units
  logic [1:0]  m_tuser;          // [1:0] phase
  logic        m_tlast;          // finished
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  bcd_mmss_countdown_timer_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  press_t    button_q[$];
  disp_exp_t disp_q[$];
  int        fail_cnt = 0;
  int        blk_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_recv = 1'b0;

  // timer model state
  logic [2:0]       tm_min_tens = 3'd0;
  logic [3:0]       tm_min_units = 4'd0;
  logic [3:0]       tm_sec_tens = 4'd0;
  logic [3:0]       tm_sec_units = 4'd0;
  logic [14:0]      tm_saved = 15'd0;
  bmct_pkg::phase_t tm_phase = bmct_pkg::PH_SETUP;
  logic [6:0]       tm_prep = bmct_pkg::PREP_RESET;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void raise_minutes();
    if (tm_min_units < bmct_pkg::UNITS_MAX) begin
      tm_min_units++;
    end else if (tm_min_tens < bmct_pkg::MIN_TENS_MAX) begin
      tm_min_units = 4'd0;
      tm_min_tens++;
    end
  endfunction

  // one second down with borrows, zero when already at 00:00
  function automatic bit second_down();
    if (tm_sec_units != 4'd0) begin
      tm_sec_units--;
    end else if (tm_sec_tens != 4'd0) begin
      tm_sec_tens--;
      tm_sec_units = bmct_pkg::UNITS_MAX;
    end else if (tm_min_units != 4'd0) begin
      tm_min_units--;
      tm_sec_tens = bmct_pkg::SEC_TENS_MAX;
      tm_sec_units = bmct_pkg::UNITS_MAX;
    end else if (tm_min_tens != 3'd0) begin
      tm_min_tens--;
      tm_min_units = bmct_pkg::UNITS_MAX;
      tm_sec_tens = bmct_pkg::SEC_TENS_MAX;
      tm_sec_units = bmct_pkg::UNITS_MAX;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic disp_exp_t timer_step(input logic [2:0] op, input logic [1:0] sel);
    disp_exp_t  r;
    logic [6:0] p;
    logic       fin;
    bit         at_top;
    fin = 1'b0;
    at_top = (tm_min_tens == bmct_pkg::MIN_TENS_MAX) && (tm_min_units == bmct_pkg::UNITS_MAX);
    case (op)
      bmct_pkg::OP_TICK: begin
        if (tm_phase == bmct_pkg::PH_PREP) begin
          void'(second_down());
          if (tm_sec_tens == 4'd0 && tm_sec_units == 4'd0) begin
            {tm_min_tens, tm_min_units, tm_sec_tens, tm_sec_units} = tm_saved;
            tm_phase = bmct_pkg::PH_MAIN;
          end
        end else if (tm_phase == bmct_pkg::PH_MAIN) begin
          if (!second_down()) begin
            tm_phase = bmct_pkg::PH_DONE;
            fin = 1'b1;
          end
        end
      end
      bmct_pkg::OP_START: begin
        if (tm_phase == bmct_pkg::PH_SETUP) begin
          tm_saved = {tm_min_tens, tm_min_units, tm_sec_tens, tm_sec_units};
          p = tm_prep;
          if (p == 7'd0) p = 7'd1;
          if (p > 7'd99) p = 7'd99;
          tm_min_tens = 3'd0;
          tm_min_units = 4'd0;
          tm_sec_tens = 4'(p / 7'd10);
          tm_sec_units = 4'(p % 7'd10);
          tm_phase = bmct_pkg::PH_PREP;
        end
      end
      bmct_pkg::OP_RAISE: begin
        if (tm_phase == bmct_pkg::PH_SETUP) begin
          case (sel)
            bmct_pkg::DIG_SEC_UNITS: begin
              if (tm_sec_units < bmct_pkg::UNITS_MAX) begin
                tm_sec_units++;
              end else if (tm_sec_tens < bmct_pkg::SEC_TENS_MAX) begin
                tm_sec_units = 4'd0;
                tm_sec_tens++;
              end else if (!at_top) begin
                tm_sec_units = 4'd0;
                tm_sec_tens = 4'd0;
                raise_minutes();
              end
            end
            bmct_pkg::DIG_SEC_TENS: begin
              if (tm_sec_tens < bmct_pkg::SEC_TENS_MAX) begin
                tm_sec_tens++;
              end else if (!at_top) begin
                tm_sec_tens = 4'd0;
                raise_minutes();
              end
            end
            bmct_pkg::DIG_MIN_UNITS: raise_minutes();
            default: begin
              if (tm_min_tens < bmct_pkg::MIN_TENS_MAX) tm_min_tens++;
            end
          endcase
        end
      end
      bmct_pkg::OP_LOWER: begin
        if (tm_phase == bmct_pkg::PH_SETUP) begin
          case (sel)
            bmct_pkg::DIG_SEC_UNITS: if (tm_sec_units != 4'd0) tm_sec_units--;
            bmct_pkg::DIG_SEC_TENS:  if (tm_sec_tens != 4'd0) tm_sec_tens--;
            bmct_pkg::DIG_MIN_UNITS: if (tm_min_units != 4'd0) tm_min_units--;
            default:                 if (tm_min_tens != 3'd0) tm_min_tens--;
          endcase
        end
      end
      bmct_pkg::OP_CLEAR: begin
        tm_min_tens = 3'd0;
        tm_min_units = 4'd0;
        tm_sec_tens = 4'd0;
        tm_sec_units = 4'd0;
        tm_phase = bmct_pkg::PH_SETUP;
      end
      default: ;
    endcase
    r.min_tens = tm_min_tens;
    r.min_units = tm_min_units;
    r.sec_tens = tm_sec_tens;
    r.sec_units = tm_sec_units;
    r.phase = tm_phase;
    r.finished = fin;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    press_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) disp_q.push_back(timer_step(s_tuser, s_tdata[1:0]));
      if (!s_tvalid || s_tready) begin
        if (button_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = button_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt.op;
          s_tdata <= {6'd0, nxt.sel};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result capture at the rising edge, compare at the falling edge
  logic        got_valid = 1'b0;
  logic [15:0] got_tdata;
  logic [1:0]  got_tuser;
  logic        got_tlast;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      got_valid <= 1'b0;
    end else begin
      got_valid <= m_tvalid && m_tready;
      got_tdata <= m_tdata;
      got_tuser <= m_tuser;
      got_tlast <= m_tlast;
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    disp_exp_t want;
    if (got_valid) begin
      if (disp_q.size() == 0) begin
        $error("result with no pending expectation: tdata %h tuser %0d tlast %0d",
               got_tdata, got_tuser, got_tlast);
        fail_cnt++;
      end else begin
        want = disp_q.pop_front();
        check_field("min_tens", 32'(want.min_tens), 32'(got_tdata[2:0]));
        check_field("min_units", 32'(want.min_units), 32'(got_tdata[6:3]));
        check_field("sec_tens", 32'(want.sec_tens), 32'(got_tdata[10:7]));
        check_field("sec_units", 32'(want.sec_units), 32'(got_tdata[14:11]));
        check_field("phase", 32'(want.phase), 32'(got_tuser));
        check_field("finished", 32'(want.finished), 32'(got_tlast));
      end
    end
  end

  task automatic apb_write(input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PREP_ADDR;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tm_prep = val[6:0];
  endtask

  task automatic push(input logic [2:0] op, input logic [1:0] sel);
    press_t b;
    b.op = op;
    b.sel = sel;
    button_q.push_back(b);
    blk_cnt++;
  endtask

  task automatic wait_idle();
    while (button_q.size() != 0 || s_tvalid || disp_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // set a short time, start, tick through prep and main countdown, mostly into done
  task automatic push_countdown(input int prep_eff);
    int nu, nt, nm, run_secs, ticks;
    push(bmct_pkg::OP_CLEAR, 2'($urandom_range(0, 3)));
    nu = $urandom_range(0, 9);
    nt = $urandom_range(0, 4);
    nm = ($urandom_range(0, 9) == 0) ? 1 : 0;
    run_secs = nu + 10 * nt + 60 * nm;
    while (nu + nt + nm > 0) begin
      case ($urandom_range(0, 2))
        0: if (nu > 0) begin push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_SEC_UNITS); nu--; end
        1: if (nt > 0) begin push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_SEC_TENS); nt--; end
        default: if (nm > 0) begin push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_MIN_UNITS); nm--; end
      endcase
    end
    if ($urandom_range(0, 3) == 0) push(bmct_pkg::OP_LOWER, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 4) == 0) push(bmct_pkg::OP_TICK, 2'($urandom_range(0, 3)));
    push(bmct_pkg::OP_START, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 4) != 0) begin
      ticks = prep_eff + run_secs + 1 + $urandom_range(0, 3);
    end else begin
      ticks = $urandom_range(1, prep_eff + run_secs);
    end
    repeat (ticks) begin
      if ($urandom_range(0, 19) == 0)
        push(3'($urandom_range(bmct_pkg::OP_START, bmct_pkg::OP_LOWER)),
             2'($urandom_range(0, 3)));
      push(bmct_pkg::OP_TICK, 2'($urandom_range(0, 3)));
    end
  endtask

  // many raises on random digits, pushes the display toward the 59:59 ceiling
  task automatic push_climb();
    push(bmct_pkg::OP_CLEAR, 2'($urandom_range(0, 3)));
    repeat ($urandom_range(40, 70)) push(bmct_pkg::OP_RAISE, 2'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 5)) push(bmct_pkg::OP_LOWER, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 1) == 0) begin
      push(bmct_pkg::OP_START, 2'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 6)) push(bmct_pkg::OP_TICK, 2'($urandom_range(0, 3)));
    end
    push(bmct_pkg::OP_CLEAR, 2'($urandom_range(0, 3)));
  endtask

  task automatic fill_block(input int cfg);
    int prep_eff, pick;
    prep_eff = (cfg == 0) ? 1 : (cfg > 99) ? 99 : cfg;
    blk_cnt = 0;
    while (blk_cnt < 110) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_countdown(prep_eff);
      end else if (pick < 75) begin
        push_climb();
      end else begin
        repeat ($urandom_range(8, 20))
          push(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    int cfg_list[8];
    int b;
    cfg_list = '{127, 3, 99, 1, 5, 2, 4, 10};
    cfg_list[4] = $urandom_range(2, 9);
    cfg_list[6] = $urandom_range(2, 9);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // prep length zero behaves as one second
    apb_write(32'd0);
    @(negedge clk);
    push(bmct_pkg::OP_TICK, bmct_pkg::DIG_SEC_UNITS);
    push(bmct_pkg::OP_LOWER, bmct_pkg::DIG_SEC_UNITS);
    push(bmct_pkg::OP_LOWER, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_MIN_UNITS);
    push(bmct_pkg::OP_LOWER, bmct_pkg::DIG_MIN_UNITS);
    push(bmct_pkg::OP_LOWER, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_SEC_TENS);
    push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_SEC_UNITS);
    push(3'd5, bmct_pkg::DIG_MIN_TENS);
    push(3'd6, bmct_pkg::DIG_SEC_TENS);
    push(3'd7, bmct_pkg::DIG_MIN_UNITS);
    push(bmct_pkg::OP_START, bmct_pkg::DIG_SEC_UNITS);
    push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_SEC_UNITS);
    push(bmct_pkg::OP_LOWER, bmct_pkg::DIG_SEC_TENS);
    push(bmct_pkg::OP_START, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_TICK, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_CLEAR, bmct_pkg::DIG_SEC_TENS);
    push(bmct_pkg::OP_START, bmct_pkg::DIG_MIN_UNITS);
    push(bmct_pkg::OP_TICK, bmct_pkg::DIG_SEC_UNITS);
    push(bmct_pkg::OP_TICK, bmct_pkg::DIG_SEC_UNITS);
    push(bmct_pkg::OP_TICK, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_RAISE, bmct_pkg::DIG_MIN_TENS);
    push(bmct_pkg::OP_START, bmct_pkg::DIG_SEC_TENS);
    push(bmct_pkg::OP_CLEAR, bmct_pkg::DIG_MIN_TENS);
    wait_idle();

    for (b = 0; b < 8; b++) begin
      apb_write(cfg_list[b]);
      @(negedge clk);
      case (b / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      fill_block(cfg_list[b]);
      if (b == 0) begin
        // long output backpressure while requests keep coming
        fork
          begin
            hold_recv <= 1'b1;
            repeat (150) @(posedge clk);
            hold_recv <= 1'b0;
          end
        join_none
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && disp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bmct_pkg.sv
rtl/bmct_cfg.sv
rtl/bmct_step.sv
rtl/bcd_mmss_countdown_timer_unit.sv
dv/tb.sv
